>>> design/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned PEND_W = 3;

  // replacement character for a bad lead byte
  localparam logic [CP_W-1:0] QUESTION_MARK = 31'd63;

  // mode register values
  localparam logic MODE_ASCII = 1'b0;
  localparam logic MODE_UTF8  = 1'b1;

  // one result request
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            string_end;
  } result_t;

  // input register stage towards the decoder
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } stage_t;

endpackage

>>> design/u8d_byte_if.sv
`timescale 1ns / 1ps

interface u8d_byte_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> design/u8d_cp_if.sv
`timescale 1ns / 1ps

interface u8d_cp_if;
  logic                     valid;
  logic                     ready;
  logic [u8d_pkg::CP_W-1:0] code_point;
  logic                     replaced;
  logic                     string_end;

  modport source (output valid, output code_point, output replaced, output string_end,
                  input ready);
  modport sink   (input valid, input code_point, input replaced, input string_end,
                  output ready);
endinterface

>>> design/u8d_in_reg.sv
`timescale 1ns / 1ps

module u8d_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  u8d_byte_if.sink          in_if,
  input  logic              take,
  output u8d_pkg::stage_t   stage
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [u8d_pkg::BYTE_W-1:0] data_r;
  logic                       load;

  // refill whenever the held byte is empty or leaves this cycle
  assign in_if.ready = !valid_r || take;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_if.in_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

>>> design/u8d_decode.sv
`timescale 1ns / 1ps

module u8d_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  u8d_pkg::stage_t     stage,
  input  logic                take,
  output logic                emit,
  output u8d_pkg::result_t    result
);

  logic                       mode_r;
  logic [u8d_pkg::CP_W-1:0]   partial_r;
  logic [u8d_pkg::CP_W-1:0]   partial_nxt;
  logic [u8d_pkg::PEND_W-1:0] pending_r;
  logic [u8d_pkg::PEND_W-1:0] pending_nxt;
  logic [u8d_pkg::PEND_W-1:0] pending_dec;
  logic [u8d_pkg::CP_W-1:0]   shifted;
  logic [u8d_pkg::CP_W-1:0]   byte_cp;
  logic [u8d_pkg::BYTE_W-1:0] b;

  assign b           = stage.data;
  assign byte_cp     = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, b};
  assign shifted     = {partial_r[u8d_pkg::CP_W-7:0], b[5:0]};
  assign pending_dec = pending_r - 3'd1;

  // one byte: end marker, pass-through, continuation or lead class
  always_comb begin
    partial_nxt = partial_r;
    pending_nxt = pending_r;
    emit        = 1'b0;
    result      = '0;
    if (b == '0) begin
      partial_nxt       = '0;
      pending_nxt       = '0;
      emit              = 1'b1;
      result.string_end = 1'b1;
    end else if (mode_r == u8d_pkg::MODE_ASCII) begin
      partial_nxt       = '0;
      pending_nxt       = '0;
      emit              = 1'b1;
      result.code_point = byte_cp;
    end else if (pending_r != '0) begin
      pending_nxt = pending_dec;
      if (pending_dec != '0) begin
        partial_nxt = shifted;
      end else begin
        partial_nxt       = '0;
        emit              = 1'b1;
        result.code_point = shifted;
      end
    end else begin
      case (b) inside
        8'b0???????: begin
          emit              = 1'b1;
          result.code_point = byte_cp;
        end
        8'b110?????: begin
          partial_nxt = {26'd0, b[4:0]};
          pending_nxt = 3'd1;
        end
        8'b1110????: begin
          partial_nxt = {27'd0, b[3:0]};
          pending_nxt = 3'd2;
        end
        8'b11110???: begin
          partial_nxt = {28'd0, b[2:0]};
          pending_nxt = 3'd3;
        end
        8'b111110??: begin
          partial_nxt = {29'd0, b[1:0]};
          pending_nxt = 3'd4;
        end
        8'b1111110?: begin
          partial_nxt = {30'd0, b[0]};
          pending_nxt = 3'd5;
        end
        default: begin
          // stray continuation or 0xfe/0xff
          partial_nxt       = '0;
          pending_nxt       = '0;
          emit              = 1'b1;
          result.code_point = u8d_pkg::QUESTION_MARK;
          result.replaced   = 1'b1;
        end
      endcase
    end
  end

  // sequence state moves only when the byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= u8d_pkg::MODE_UTF8;
      partial_r <= '0;
      pending_r <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (take) begin
        partial_r <= partial_nxt;
        pending_r <= pending_nxt;
      end
    end
  end

endmodule

>>> design/u8d_out_reg.sv
`timescale 1ns / 1ps

module u8d_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8d_pkg::result_t  result,
  output logic              can_take,
  u8d_cp_if.source          out_if
);

  logic             valid_r;
  logic             valid_nxt;
  u8d_pkg::result_t data_r;

  // slot free when empty or being drained now
  assign can_take = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= result;
    end
  end

  assign out_if.valid      = valid_r;
  assign out_if.code_point = data_r.code_point;
  assign out_if.replaced   = data_r.replaced;
  assign out_if.string_end = data_r.string_end;

endmodule

>>> design/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in_if     in   valid / ready      in_byte[7:0]
// out_if    out  valid / ready      code_point[30:0], replaced, string_end
// cfg       in   cfg_we             cfg_wdata (decode mode, 1 = UTF-8)
//
// One byte per cycle while out_if does not stall: byte register, decode
// logic with the sequence state, result register, from which results leave.
// Reset (rst_n low at a clock edge) empties both registers, clears any open
// sequence and selects UTF-8 mode.
// A stall on out_if holds the byte register, even for a byte with no result;
// one more byte is taken while a result waits, then in_if stalls too.

module utf8_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  u8d_byte_if.sink  in_if,
  u8d_cp_if.source  out_if,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  u8d_pkg::stage_t  stage;
  u8d_pkg::result_t result;
  logic             can_take;
  logic             take;
  logic             emit;

  // decoder consumes the held byte when the result slot is free
  assign take = stage.valid && can_take;

  u8d_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (take),
    .stage (stage)
  );

  u8d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .take      (take),
    .emit      (emit),
    .result    (result)
  );

  u8d_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take && emit),
    .result   (result),
    .can_take (can_take),
    .out_if   (out_if)
  );

endmodule
